@@ rtl/assert_macros.svh @@
// Assertion macros shared by the light-gun mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LGCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define LGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lgcm_pkg.sv @@
// Shared types, constants and the x mapping function of the light-gun mapper.
`timescale 1ns / 1ps

package lgcm_pkg;

  // Fixed-point layout: signed 11.10, 1.0 = 1024.
  localparam int MAP_W = 19;  // mapped x, 0 .. 325416
  localparam int OFF_W = 19;  // calibration offsets, signed
  localparam int POS_W = 21;  // signed position before taking the integer part
  localparam int FRAC_W = 10;
  localparam int CRS_W = 11;

  localparam int MAPX_MAX = 325416;  // 149 * 2184

  localparam logic [11:0] K_MAP = 12'd2184;    // 2.13333
  localparam logic [11:0] K_SCALE = 12'd2580;  // 2.52
  localparam logic [7:0] WIN_LO = 8'd30;
  localparam logic [7:0] WIN_HI = 8'd180;

  localparam logic [POS_W-1:0] CENTRE_X = 21'd163840;  // 160.0
  localparam logic [POS_W-1:0] CENTRE_Y = 21'd114688;  // 112.0
  localparam logic signed [POS_W-1:0] SPRITE_HALF = 21'sd8192;  // 8.0

  // Input item kinds.
  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TRIG = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused, behaves as a position sample

  // Render modes.
  localparam logic [1:0] REND_RAW = 2'd0;
  localparam logic [1:0] REND_MAP = 2'd1;
  localparam logic [1:0] REND_CAL = 2'd2;
  localparam logic [1:0] REND_SPARE = 2'd3;  // unused, renders as raw scaling

  // Calibration state as seen after the current item.
  typedef struct packed {
    logic active;
    logic [3:0] taken;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
  } lgcm_cal_t;

  // Linear map of the raw x reading, zero outside the valid window.
  function automatic logic [MAP_W-1:0] map_x(input logic [7:0] x);
    logic [7:0] d;
    d = x - WIN_LO;
    if (x < WIN_LO || x >= WIN_HI) begin
      return '0;
    end
    return MAP_W'(d) * MAP_W'(K_MAP);
  endfunction

endpackage

@@ rtl/lgcm_calib.sv @@
// Calibration state: sample sums, sample counter and offset computation.
`timescale 1ns / 1ps

module lgcm_calib #(
  parameter int SAMPLES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        mode,
  input  logic [7:0]        raw_x,
  input  logic [7:0]        raw_y,
  output lgcm_pkg::lgcm_cal_t cal
);
  import lgcm_pkg::*;

  `include "assert_macros.svh"

  localparam int SUM_W = $clog2(MAPX_MAX * SAMPLES + 1);
  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int LG = $clog2(SAMPLES);
  localparam int SH = SUM_W + LG;
  localparam int REC_W = SUM_W + 1;
  localparam int PROD_W = SH + MAP_W;
  // Reciprocal that gives the exact truncated quotient for any sum below 2^SUM_W.
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES);

  logic [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [SUM_W-1:0] add_x, add_y;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CNT_W+3:0] cnt_ext;
  logic             active_r, active_nxt;
  logic [OFF_W-1:0] off_x_r, off_x_nxt, off_y_r, off_y_nxt;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [MAP_W-1:0] q_x, q_y;
  logic             start, trig, done;

  always_comb begin
    start = fire && (mode == MODE_START);
    trig = fire && (mode == MODE_TRIG) && active_r;
    add_x = sum_x_r + SUM_W'(map_x(raw_x));
    add_y = sum_y_r + SUM_W'({raw_y, 10'b0});
    cnt_inc = cnt_r + CNT_W'(1);
    done = trig && (cnt_inc == CNT_LAST);

    // Averages by multiplying with the reciprocal of the sample count.
    prod_x = PROD_W'(add_x) * PROD_W'(RECIP);
    prod_y = PROD_W'(add_y) * PROD_W'(RECIP);
    q_x = prod_x[SH +: MAP_W];
    q_y = prod_y[SH +: MAP_W];

    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt = cnt_r;
    active_nxt = active_r;
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    if (start) begin
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      cnt_nxt = '0;
      active_nxt = 1'b1;
    end else if (trig) begin
      sum_x_nxt = add_x;
      sum_y_nxt = add_y;
      cnt_nxt = cnt_inc;
      if (done) begin
        cnt_nxt = '0;
        active_nxt = 1'b0;
        off_x_nxt = OFF_W'(CENTRE_X - POS_W'(q_x));
        off_y_nxt = OFF_W'(CENTRE_Y - POS_W'(q_y));
      end
    end

    cnt_ext = (CNT_W + 4)'(cnt_nxt);
    cal.active = active_nxt;
    cal.taken = cnt_ext[3:0];
    cal.off_x = off_x_nxt;
    cal.off_y = off_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r <= '0;
      active_r <= 1'b0;
      off_x_r <= '0;
      off_y_r <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r <= cnt_nxt;
      active_r <= active_nxt;
      off_x_r <= off_x_nxt;
      off_y_r <= off_y_nxt;
    end
  end

  `LGCM_ASSERT(a_idle_cnt_zero, !active_r |-> cnt_r == '0, "count nonzero while idle")
  `LGCM_ASSERT(a_cnt_below_last, cnt_r < CNT_LAST, "sample count reached its limit")
  `LGCM_ASSERT_NEXT(a_start_clears, start, active_r && cnt_r == '0 && sum_x_r == '0, "start did not clear")

endmodule

@@ rtl/lgcm_map.sv @@
// Coordinate mapping from raw readings to crosshair pixel positions.
`timescale 1ns / 1ps

module lgcm_map (
  input  logic [1:0]               render_mode,
  input  logic [7:0]               raw_x,
  input  logic [7:0]               raw_y,
  input  lgcm_pkg::lgcm_cal_t      cal,
  output logic signed [10:0]       cross_x,
  output logic signed [10:0]       cross_y
);
  import lgcm_pkg::*;

  logic signed [POS_W-1:0] mx, yy, ox, oy, px, py;

  always_comb begin
    mx = $signed(POS_W'(map_x(raw_x)));
    yy = $signed(POS_W'({raw_y, 10'b0}));
    ox = POS_W'($signed(cal.off_x));
    oy = POS_W'($signed(cal.off_y));
    case (render_mode)
      REND_MAP: begin
        px = mx - SPRITE_HALF;
        py = yy - SPRITE_HALF;
      end
      REND_CAL: begin
        px = mx + ox - SPRITE_HALF;
        py = yy + oy - SPRITE_HALF;
      end
      default: begin
        px = $signed(POS_W'(raw_x) * POS_W'(K_SCALE));
        py = yy - SPRITE_HALF;
      end
    endcase
    // Arithmetic shift keeps the floor of the fixed value.
    cross_x = px[POS_W-1:FRAC_W];
    cross_y = py[POS_W-1:FRAC_W];
  end

endmodule

@@ rtl/light_gun_calibrate_map.sv @@
// Top level of the light-gun crosshair mapper with trigger calibration.
// Each beat passes the input register, then the result register. Throughput: one input beat
// per cycle unless the result stalls; the input register and the result register each hold
// one item, so a stalled result still leaves room for one more input beat.
// Reset (rst_n low at a clock edge) clears render mode, sums, count, offsets and valids.
`timescale 1ns / 1ps

module light_gun_calibrate_map #(
  parameter int SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // raw_x [7:0], raw_y [15:8]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cross_x [10:0], cross_y [21:11], samples_taken [25:22]
  output logic        out_tuser,  // calibrating
  // Render mode register.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import lgcm_pkg::*;

  `include "assert_macros.svh"

  logic [1:0]  rmode_r;

  // Input stage.
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_mode_r;
  logic [7:0]  s1_rx_r, s1_ry_r;
  logic        s1_adv, fire, in_acc;

  // Result stage.
  logic        out_valid_r, out_valid_nxt;
  logic signed [CRS_W-1:0] cx_r, cy_r, cx, cy;
  logic        calib_r;
  logic [3:0]  taken_r;

  lgcm_cal_t   cal;

  // The user must write the render mode register only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= REND_RAW;
    end else if (cfg_wr_en) begin
      rmode_r <= cfg_wr_data;
    end
  end

  // The input stage moves on whenever the result register is empty or being drained.
  assign s1_adv = !out_valid_r || out_tready;
  assign fire = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = fire || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_tuser;
      s1_rx_r <= in_tdata[7:0];
      s1_ry_r <= in_tdata[15:8];
    end
  end

  // Calibration state is updated as the item leaves the input stage, and the
  // result of that same item already sees the updated offsets.
  lgcm_calib #(
    .SAMPLES(SAMPLES)
  ) u_calib (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .mode  (s1_mode_r),
    .raw_x (s1_rx_r),
    .raw_y (s1_ry_r),
    .cal   (cal)
  );

  lgcm_map u_map (
    .render_mode (rmode_r),
    .raw_x       (s1_rx_r),
    .raw_y       (s1_ry_r),
    .cal         (cal),
    .cross_x     (cx),
    .cross_y     (cy)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      cx_r <= cx;
      cy_r <= cy;
      calib_r <= cal.active;
      taken_r <= cal.taken;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'b0, taken_r, cy_r, cx_r};
  assign out_tuser = calib_r;

  `LGCM_ASSERT(a_stall_full, !in_tready |-> s1_valid_r && out_valid_r, "input stalled with room")
  `LGCM_ASSERT(a_idle_no_samples, out_valid_r && !calib_r |-> taken_r == 4'd0, "samples while idle")
  `LGCM_ASSERT_NEXT(a_fire_loads, fire, out_valid_r, "result register not loaded")

endmodule
